// File: rtl/mcr_pkg.sv
`timescale 1ns / 1ps
package mcr_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_NORMAL_PRESENT   = 2'd0;
	localparam logic [1:0] CFG_ADVANCED_PRESENT = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT_TICKS    = 2'd2;

	localparam logic [15:0] TIMEOUT_RESET    = 16'd2048;
	localparam logic [5:0]  CODE_SILENT      = 6'h3f;
	localparam logic [5:0]  CODE_GO_ADVANCED = 6'h3c;
	localparam logic [8:0]  ADV_BASE         = 9'h100;
	localparam logic [23:0] CODE_GO_NORMAL   = 24'hf3cf3c;
	localparam logic [4:0]  NORMAL_BITS      = 5'd9;
	localparam logic [4:0]  ADVANCED_BITS    = 5'd24;
	localparam logic [4:0]  COUNT_MAX        = 5'd25;
	localparam int          VOLUME_SHIFT     = 4;

	// play states
	localparam logic [1:0] PLAY_IDLE = 2'd0;
	localparam logic [1:0] PLAY_ONCE = 2'd1;
	localparam logic [1:0] PLAY_LOOP = 2'd2;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_STOP   = 2'd1,
		ACT_PLAY   = 2'd2,
		ACT_APPEND = 2'd3
	} mcr_action_t;

	typedef struct packed {
		logic kind;
		logic data_high;
		logic clock_high;
		logic audio_idle;
	} mcr_item_t;

	typedef struct packed {
		logic [1:0] action;
		logic [3:0] slot_mask;
		logic [8:0] melody_first;
		logic [8:0] melody_second;
		logic [8:0] melody_third;
		logic [8:0] melody_fourth;
		logic [6:0] volume_scale;
		logic       playing;
		logic       looping;
		logic       advanced_mode;
	} mcr_result_t;

endpackage

// File: rtl/mcr_item_if.sv
`timescale 1ns / 1ps
interface mcr_item_if;
	logic valid;
	logic ready;
	logic kind;
	logic data_high;
	logic clock_high;
	logic audio_idle;

	modport source (output valid, kind, data_high, clock_high, audio_idle, input ready);
	modport sink (input valid, kind, data_high, clock_high, audio_idle, output ready);
endinterface

// File: rtl/mcr_result_if.sv
`timescale 1ns / 1ps
interface mcr_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [3:0] slot_mask;
	logic [8:0] melody_first;
	logic [8:0] melody_second;
	logic [8:0] melody_third;
	logic [8:0] melody_fourth;
	logic [6:0] volume_scale;
	logic       playing;
	logic       looping;
	logic       advanced_mode;

	modport source (output valid, action, slot_mask, melody_first, melody_second,
		melody_third, melody_fourth, volume_scale, playing, looping, advanced_mode,
		input ready);
	modport sink (input valid, action, slot_mask, melody_first, melody_second,
		melody_third, melody_fourth, volume_scale, playing, looping, advanced_mode,
		output ready);
endinterface

// File: rtl/mcr_cfg_if.sv
`timescale 1ns / 1ps
interface mcr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [63:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/mcr_core.sv
`timescale 1ns / 1ps
module mcr_core (
	input  logic                clk,
	input  logic                arst_n,
	mcr_cfg_if.sink             cfg,
	input  logic                accept,
	input  mcr_pkg::mcr_item_t  item,
	output mcr_pkg::mcr_result_t res
);
	import mcr_pkg::*;

	typedef struct packed {
		logic [1:0] action;
		logic [5:0] mel;
		logic [8:0] last;
		logic [1:0] vol;
		logic [1:0] play;
		logic       adv;
	} mcr_norm_t;

	// configuration
	logic [63:0] normal_present_q;
	logic [63:0] advanced_present_q;
	logic [15:0] timeout_ticks_q;

	// receiver and play state
	logic        prev_clock_q;
	logic        prev_data_q;
	logic        receiving_q;
	logic [4:0]  bit_count_q;
	logic [23:0] shift_bits_q;
	logic [15:0] silence_q;
	logic        in_advanced_q;
	logic [1:0]  play_q;
	logic [8:0]  last_cmd_q;
	logic [1:0]  volume_q;

	logic        prev_clock_n;
	logic        prev_data_n;
	logic        receiving_n;
	logic [4:0]  bit_count_n;
	logic [23:0] shift_bits_n;
	logic [15:0] silence_n;
	logic        in_advanced_n;
	logic [1:0]  play_n;
	logic [8:0]  last_cmd_n;
	logic [1:0]  volume_n;
	mcr_result_t res_n;

	// one normal-mode command: stop, mode switch or single/looped play
	function automatic mcr_norm_t run_normal(input logic [8:0] cmd, input logic [63:0] np,
		input logic capable, input logic adv);
		mcr_norm_t r;
		r.mel    = cmd[5:0];
		r.last   = cmd;
		r.vol    = cmd[7:6];
		r.play   = PLAY_IDLE;
		r.action = ACT_STOP;
		r.adv    = adv;
		if (cmd[5:0] == CODE_SILENT) begin
			r.action = ACT_STOP;
		end else if (capable && cmd[5:0] == CODE_GO_ADVANCED) begin
			r.adv = 1'b1;
		end else if (np[cmd[5:0]]) begin
			r.action = ACT_PLAY;
			r.play   = cmd[8] ? PLAY_LOOP : PLAY_ONCE;
		end
		return r;
	endfunction

	assign cfg.ready = 1'b1;

	// next state and result for one item
	always_comb begin
		mcr_norm_t   nr;
		logic        fire;
		logic [3:0]  mask;
		logic [5:0]  idx [4];
		logic [2:0]  vol_p1;
		prev_clock_n  = prev_clock_q;
		prev_data_n   = prev_data_q;
		receiving_n   = receiving_q;
		bit_count_n   = bit_count_q;
		shift_bits_n  = shift_bits_q;
		silence_n     = silence_q;
		in_advanced_n = in_advanced_q;
		play_n        = play_q;
		last_cmd_n    = last_cmd_q;
		volume_n      = volume_q;
		res_n         = '0;
		nr            = '0;
		fire          = 1'b0;
		mask          = '0;
		for (int k = 0; k < 4; k++) begin
			idx[k] = shift_bits_q[23 - 6 * k -: 6];
		end
		if (!item.kind) begin
			// pin change: start pulse or data bit
			if (!prev_clock_q && !prev_data_q && !item.clock_high && item.data_high) begin
				bit_count_n  = '0;
				shift_bits_n = '0;
				silence_n    = '0;
				receiving_n  = 1'b1;
			end else if (receiving_q && !prev_clock_q && !prev_data_q && item.clock_high) begin
				shift_bits_n = {shift_bits_q[22:0], item.data_high};
				if (bit_count_q < COUNT_MAX) begin
					bit_count_n = bit_count_q + 5'd1;
				end
				silence_n = '0;
			end
			prev_clock_n = item.clock_high;
			prev_data_n  = item.data_high;
		end else begin
			// tick: age silence, decode at timeout
			if (silence_q != 16'hffff) begin
				silence_n = silence_q + 16'd1;
			end
			fire = receiving_q && bit_count_q != 5'd0 && silence_n >= timeout_ticks_q;
			if (fire) begin
				bit_count_n = '0;
				receiving_n = 1'b0;
				if (bit_count_q == NORMAL_BITS && !in_advanced_q) begin
					nr = run_normal(shift_bits_q[8:0], normal_present_q,
						advanced_present_q != '0, in_advanced_q);
					last_cmd_n    = nr.last;
					volume_n      = nr.vol;
					play_n        = nr.play;
					in_advanced_n = nr.adv;
					res_n.action  = nr.action;
					if (nr.action == ACT_PLAY) begin
						res_n.slot_mask    = 4'b0001;
						res_n.melody_first = {3'b000, nr.mel};
					end
				end else if (bit_count_q == ADVANCED_BITS && in_advanced_q) begin
					if (shift_bits_q == CODE_GO_NORMAL) begin
						res_n.action  = ACT_STOP;
						play_n        = PLAY_IDLE;
						in_advanced_n = 1'b0;
					end else begin
						for (int k = 0; k < 4; k++) begin
							mask[k] = advanced_present_q[idx[k]];
						end
						if (mask != '0) begin
							res_n.action        = ACT_APPEND;
							res_n.slot_mask     = mask;
							res_n.melody_first  = ADV_BASE | {3'b000, idx[0]};
							res_n.melody_second = ADV_BASE | {3'b000, idx[1]};
							res_n.melody_third  = ADV_BASE | {3'b000, idx[2]};
							res_n.melody_fourth = ADV_BASE | {3'b000, idx[3]};
							play_n              = PLAY_ONCE;
						end else begin
							play_n = PLAY_IDLE;
						end
					end
				end
			end
			// end of audio: finish a single play or restart a loop
			if (res_n.action != ACT_PLAY && res_n.action != ACT_APPEND && play_n != PLAY_IDLE
				&& item.audio_idle) begin
				if (play_n == PLAY_ONCE) begin
					play_n = PLAY_IDLE;
				end else begin
					nr = run_normal(last_cmd_n, normal_present_q,
						advanced_present_q != '0, in_advanced_n);
					last_cmd_n    = nr.last;
					volume_n      = nr.vol;
					play_n        = nr.play;
					in_advanced_n = nr.adv;
					res_n.action  = nr.action;
					if (nr.action == ACT_PLAY) begin
						res_n.slot_mask    = 4'b0001;
						res_n.melody_first = {3'b000, nr.mel};
					end
				end
			end
		end
		vol_p1              = {1'b0, volume_n} + 3'd1;
		res_n.volume_scale  = {vol_p1, {VOLUME_SHIFT{1'b0}}};
		res_n.playing       = play_n != PLAY_IDLE;
		res_n.looping       = play_n == PLAY_LOOP;
		res_n.advanced_mode = in_advanced_n;
	end

	assign res = res_n;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_present_q   <= '0;
			advanced_present_q <= '0;
			timeout_ticks_q    <= TIMEOUT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_NORMAL_PRESENT:   normal_present_q   <= cfg.data;
				CFG_ADVANCED_PRESENT: advanced_present_q <= cfg.data;
				CFG_TIMEOUT_TICKS:    timeout_ticks_q    <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	// state update on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_clock_q  <= 1'b0;
			prev_data_q   <= 1'b0;
			receiving_q   <= 1'b0;
			bit_count_q   <= '0;
			shift_bits_q  <= '0;
			silence_q     <= '0;
			in_advanced_q <= 1'b0;
			play_q        <= PLAY_IDLE;
			last_cmd_q    <= '0;
			volume_q      <= '0;
		end else if (accept) begin
			prev_clock_q  <= prev_clock_n;
			prev_data_q   <= prev_data_n;
			receiving_q   <= receiving_n;
			bit_count_q   <= bit_count_n;
			shift_bits_q  <= shift_bits_n;
			silence_q     <= silence_n;
			in_advanced_q <= in_advanced_n;
			play_q        <= play_n;
			last_cmd_q    <= last_cmd_n;
			volume_q      <= volume_n;
		end
	end

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= COUNT_MAX)
		else $error("bit count above saturation");
	a_play_code: assert property (@(posedge clk) disable iff (!arst_n)
		play_q == PLAY_IDLE || play_q == PLAY_ONCE || play_q == PLAY_LOOP)
		else $error("bad play state");
	a_append_mask: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res_n.action == ACT_APPEND |-> res_n.slot_mask != '0 && in_advanced_q)
		else $error("advanced play without slot");
	a_idle_rcv: assert property (@(posedge clk) disable iff (!arst_n)
		!receiving_q && accept && item.kind |=> bit_count_q == $past(bit_count_q))
		else $error("bit count moved while not receiving");
endmodule

// File: rtl/melody_command_receiver_top.sv
`timescale 1ns / 1ps
// Two-wire command receiver and play controller for a melody chip.
// item channel: one request per pin change (kind 0, new clock and data
// levels) or per time tick (kind 1, with the player's audio_idle flag).
// result channel: exactly one reply per request with the play action,
// slot mask, four melody indexes, volume scale and play/loop/mode flags.
// cfg channel: writes normal_present (0), advanced_present (1) and
// timeout_ticks (2); it is always ready and should only be used while
// no request is outstanding.
// A reply is registered in the output register (the skid register under a stall).
// Throughput: one request per cycle while item.ready is high; all decode is
// one pass of logic between the state registers and the output register.
// When the receiver stalls, a skid register absorbs one more reply and
// item.ready then drops until the output register drains.
// Reset (arst_n low) clears all receive and play state, empties the output
// stages and restores timeout_ticks to 2048 and the presence maps to zero.
module melody_command_receiver_top (
	input  logic        clk,
	input  logic        arst_n,
	mcr_item_if.sink    item,
	mcr_result_if.source result,
	mcr_cfg_if.sink     cfg
);
	import mcr_pkg::*;

	logic        accept;
	mcr_item_t   item_pl;
	mcr_result_t res_new;
	mcr_result_t out_s1;
	mcr_result_t skid_q;
	logic        out_v_s1;
	logic        skid_v_q;

	assign item.ready = !skid_v_q;
	assign accept     = item.valid && item.ready;
	assign item_pl    = '{kind: item.kind, data_high: item.data_high,
		clock_high: item.clock_high, audio_idle: item.audio_idle};

	mcr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.accept (accept),
		.item   (item_pl),
		.res    (res_new)
	);

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s1 <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_s1 || result.ready) begin
			out_v_s1 <= skid_v_q || accept;
			skid_v_q <= 1'b0;
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_s1 || result.ready) begin
			out_s1 <= skid_v_q ? skid_q : res_new;
		end else if (accept) begin
			skid_q <= res_new;
		end
	end

	assign result.valid         = out_v_s1;
	assign result.action        = out_s1.action;
	assign result.slot_mask     = out_s1.slot_mask;
	assign result.melody_first  = out_s1.melody_first;
	assign result.melody_second = out_s1.melody_second;
	assign result.melody_third  = out_s1.melody_third;
	assign result.melody_fourth = out_s1.melody_fourth;
	assign result.volume_scale  = out_s1.volume_scale;
	assign result.playing       = out_s1.playing;
	assign result.looping       = out_s1.looping;
	assign result.advanced_mode = out_s1.advanced_mode;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_s1)
		else $error("skid holds a reply while output register is empty");
	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_s1 && !result.ready && accept |=> skid_v_q && out_v_s1)
		else $error("reply lost under stall");
	a_accept_shows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (!out_v_s1 || result.ready) |=> out_v_s1)
		else $error("accepted request produced no reply");
endmodule

// File: sim/melody_reply_checker.sv
`timescale 1ns / 1ps
module melody_reply_checker (
	input  logic  clk,
	input  logic  arst_n,
	mcr_item_if   item,
	mcr_result_if result,
	mcr_cfg_if    cfg,
	output int    failures,
	output int    waiting,
	output int    replies_checked,
	output int    stops_seen,
	output int    plays_seen,
	output int    appends_seen
);
	import mcr_pkg::*;

	// register copies
	logic [63:0] normal_map;
	logic [63:0] adv_map;
	logic [15:0] quiet_limit;

	// receiver and player state
	logic        line_clk;
	logic        line_data;
	logic        in_frame;
	logic [4:0]  frame_len;
	logic [23:0] frame_shift;
	logic [15:0] quiet_ticks;
	logic        adv_mode;
	logic [1:0]  play_st;
	logic [8:0]  last_cmd;
	logic [1:0]  volume;

	mcr_result_t replies_due[$];

	// 9-bit command: stop, enter advanced, or play one melody
	function automatic void decode_normal(input logic [8:0] cmd, inout mcr_result_t r);
		logic [5:0] code;
		code = cmd[5:0];
		last_cmd = cmd;
		volume = cmd[7:6];
		play_st = PLAY_IDLE;
		r.action = ACT_STOP;
		if (code == CODE_GO_ADVANCED && adv_map != '0) begin
			adv_mode = 1'b1;
		end else if (code != CODE_SILENT && normal_map[code]) begin
			r.action = ACT_PLAY;
			r.slot_mask = 4'b0001;
			r.melody_first = {3'b000, code};
			play_st = cmd[8] ? PLAY_LOOP : PLAY_ONCE;
		end
	endfunction

	// 24-bit command: leave advanced, or append a four slot instrument play
	function automatic void decode_advanced(input logic [23:0] cmd, inout mcr_result_t r);
		logic [3:0] hits;
		hits = {adv_map[cmd[5:0]], adv_map[cmd[11:6]], adv_map[cmd[17:12]],
			adv_map[cmd[23:18]]};
		if (cmd == CODE_GO_NORMAL) begin
			r.action = ACT_STOP;
			play_st = PLAY_IDLE;
			adv_mode = 1'b0;
		end else if (hits != '0) begin
			r.action = ACT_APPEND;
			r.slot_mask = hits;
			r.melody_first = ADV_BASE | {3'b000, cmd[23:18]};
			r.melody_second = ADV_BASE | {3'b000, cmd[17:12]};
			r.melody_third = ADV_BASE | {3'b000, cmd[11:6]};
			r.melody_fourth = ADV_BASE | {3'b000, cmd[5:0]};
			play_st = PLAY_ONCE;
		end else begin
			play_st = PLAY_IDLE;
		end
	endfunction

	// next state and reply for one request
	function automatic mcr_result_t predict_reply(input logic kind, input logic dat,
		input logic clk_lvl, input logic idle);
		mcr_result_t r;
		logic [4:0] len;
		r = '0;
		if (!kind) begin
			if (!line_clk && !line_data && !clk_lvl && dat) begin
				frame_len = '0;
				frame_shift = '0;
				quiet_ticks = '0;
				in_frame = 1'b1;
			end else if (in_frame && !line_clk && !line_data && clk_lvl) begin
				frame_shift = {frame_shift[22:0], dat};
				if (frame_len < COUNT_MAX)
					frame_len = frame_len + 5'd1;
				quiet_ticks = '0;
			end
			line_clk = clk_lvl;
			line_data = dat;
		end else begin
			if (quiet_ticks != 16'hffff)
				quiet_ticks = quiet_ticks + 16'd1;
			if (in_frame && frame_len != '0 && quiet_ticks >= quiet_limit) begin
				len = frame_len;
				frame_len = '0;
				in_frame = 1'b0;
				if (len == NORMAL_BITS && !adv_mode)
					decode_normal(frame_shift[8:0], r);
				else if (len == ADVANCED_BITS && adv_mode)
					decode_advanced(frame_shift, r);
			end
			// queue ran dry: a single play ends, a looped one starts over
			if (r.action != ACT_PLAY && r.action != ACT_APPEND && play_st != PLAY_IDLE
				&& idle) begin
				if (play_st == PLAY_ONCE)
					play_st = PLAY_IDLE;
				else
					decode_normal(last_cmd, r);
			end
		end
		r.volume_scale = {3'({1'b0, volume} + 3'd1), 4'b0000};
		r.playing = play_st != PLAY_IDLE;
		r.looping = play_st == PLAY_LOOP;
		r.advanced_mode = adv_mode;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [8:0] want,
		input logic [8:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mcr_result_t want;
		if (!arst_n) begin
			normal_map = '0;
			adv_map = '0;
			quiet_limit = TIMEOUT_RESET;
			line_clk = 1'b0;
			line_data = 1'b0;
			in_frame = 1'b0;
			frame_len = '0;
			frame_shift = '0;
			quiet_ticks = '0;
			adv_mode = 1'b0;
			play_st = PLAY_IDLE;
			last_cmd = '0;
			volume = '0;
			replies_due.delete();
			failures = 0;
			waiting = 0;
			replies_checked = 0;
			stops_seen = 0;
			plays_seen = 0;
			appends_seen = 0;
		end else begin
			// register writes
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_NORMAL_PRESENT:   normal_map = cfg.data;
					CFG_ADVANCED_PRESENT: adv_map = cfg.data;
					CFG_TIMEOUT_TICKS:    quiet_limit = cfg.data[15:0];
					default: ;
				endcase
			end
			// compare each reply with the oldest prediction
			if (result.valid && result.ready) begin
				if (replies_due.size() == 0) begin
					$display("%0t: reply with no request outstanding, expected none, got action %0d",
						$time, result.action);
					failures++;
				end else begin
					want = replies_due.pop_front();
					check_field("action", 9'(want.action), 9'(result.action));
					check_field("slot_mask", 9'(want.slot_mask), 9'(result.slot_mask));
					check_field("melody_first", want.melody_first, result.melody_first);
					check_field("melody_second", want.melody_second, result.melody_second);
					check_field("melody_third", want.melody_third, result.melody_third);
					check_field("melody_fourth", want.melody_fourth, result.melody_fourth);
					check_field("volume_scale", 9'(want.volume_scale), 9'(result.volume_scale));
					check_field("playing", 9'(want.playing), 9'(result.playing));
					check_field("looping", 9'(want.looping), 9'(result.looping));
					check_field("advanced_mode", 9'(want.advanced_mode), 9'(result.advanced_mode));
					replies_checked++;
					case (want.action)
						ACT_STOP:   stops_seen++;
						ACT_PLAY:   plays_seen++;
						ACT_APPEND: appends_seen++;
						default: ;
					endcase
				end
			end
			// predict the reply of each accepted request
			if (item.valid && item.ready)
				replies_due.push_back(predict_reply(item.kind, item.data_high, item.clock_high,
					item.audio_idle));
			waiting = replies_due.size();
		end
	end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import mcr_pkg::*;

	localparam logic KIND_PIN  = 1'b0;
	localparam logic KIND_TICK = 1'b1;
	localparam int   STUCK_LIMIT = 1000;
	localparam int   RANDOM_ITEMS = 2000;

	logic clk = 1'b0;
	logic arst_n;
	logic no_gaps = 1'b0;
	logic mode_seen = 1'b0;
	int   items_sent = 0;
	int   phases = 0;
	int   tick_limit = TIMEOUT_RESET;
	int   stuck_cycles = 0;
	int   random_start;

	int failures;
	int waiting;
	int replies_checked;
	int stops_seen;
	int plays_seen;
	int appends_seen;

	mcr_item_if   item();
	mcr_result_if result();
	mcr_cfg_if    cfg();

	melody_command_receiver_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

	melody_reply_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.item            (item),
		.result          (result),
		.cfg             (cfg),
		.failures        (failures),
		.waiting         (waiting),
		.replies_checked (replies_checked),
		.stops_seen      (stops_seen),
		.plays_seen      (plays_seen),
		.appends_seen    (appends_seen)
	);

	always #5 clk = ~clk;

	// one request per call, after a random gap
	task automatic send_item(input logic kind, input logic dat, input logic clk_lvl,
		input logic idle);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item.valid <= 1'b1;
		item.kind <= kind;
		item.data_high <= dat;
		item.clock_high <= clk_lvl;
		item.audio_idle <= idle;
		do @(posedge clk); while (!item.ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic pin(input logic dat, input logic clk_lvl);
		send_item(KIND_PIN, dat, clk_lvl, 1'($urandom_range(0, 1)));
	endtask

	task automatic tick();
		send_item(KIND_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	// start pulse, bits msb first, then at least tick_limit silence ticks
	task automatic send_frame(input logic [31:0] bits, input int len);
		int i;
		pin(1'b0, 1'b0);
		pin(1'b1, 1'b0);
		for (i = len - 1; i >= 0; i--) begin
			pin(1'b0, 1'b0);
			pin(bits[i], 1'b1);
		end
		repeat (tick_limit == 0 ? 1 : tick_limit) tick();
		repeat ($urandom_range(0, 3)) tick();
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= index;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
	endtask

	// drain all replies, then load all three registers
	task automatic set_config(input logic [63:0] nmap, input logic [63:0] amap,
		input logic [15:0] limit);
		item.valid <= 1'b0;
		while (waiting != 0) @(negedge clk);
		@(negedge clk);
		write_reg(CFG_NORMAL_PRESENT, nmap);
		write_reg(CFG_ADVANCED_PRESENT, amap);
		write_reg(CFG_TIMEOUT_TICKS, {48'd0, limit});
		cfg.valid <= 1'b0;
		tick_limit = limit;
		phases++;
	endtask

	function automatic logic [63:0] pick_map();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return {$urandom, $urandom};
			default: return 64'd1 << $urandom_range(0, 63);
		endcase
	endfunction

	// mostly commands of the current mode, some odd lengths and line noise
	task automatic random_transfer();
		int pick;
		int len;
		logic [31:0] bits;
		pick = $urandom_range(0, 99);
		bits = $urandom;
		if (pick < 12) begin
			repeat ($urandom_range(1, 8))
				send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end else begin
			if (pick < 24)
				len = $urandom_range(1, 31);
			else if (pick < 32)
				len = mode_seen ? NORMAL_BITS : ADVANCED_BITS;
			else
				len = mode_seen ? ADVANCED_BITS : NORMAL_BITS;
			if (len == NORMAL_BITS) begin
				case ($urandom_range(0, 9))
					0: bits[5:0] = CODE_SILENT;
					1: bits[5:0] = CODE_GO_ADVANCED;
					default: ;
				endcase
			end else if (len == ADVANCED_BITS && $urandom_range(0, 6) == 0) begin
				bits[23:0] = CODE_GO_NORMAL;
			end
			send_frame(bits, len);
		end
	endtask

	// track the mode to steer command lengths
	always @(posedge clk)
		if (result.valid && result.ready)
			mode_seen <= result.advanced_mode;

	// reply side ready with random stalls
	initial begin
		int stall;
		result.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 12);
			if (stall != 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
			@(negedge clk);
		end
	end

	// watchdog on cycles with no request, reply or register write
	always @(posedge clk) begin
		if (!arst_n || (item.valid && item.ready) || (result.valid && result.ready)
			|| (cfg.valid && cfg.ready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		item.valid <= 1'b0;
		item.kind <= KIND_PIN;
		item.data_high <= 1'b0;
		item.clock_high <= 1'b0;
		item.audio_idle <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= CFG_NORMAL_PRESENT;
		cfg.data <= '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// line levels and tick flags under reset defaults; a short silence
		// leaves the command pending under the default timeout
		pin(1'b1, 1'b1);
		pin(1'b0, 1'b0);
		send_item(KIND_TICK, 1'b1, 1'b1, 1'b1);
		send_item(KIND_TICK, 1'b0, 1'b0, 1'b0);
		tick_limit = 8;
		send_frame(32'h0C5, NORMAL_BITS);

		// every melody present, shortest silence; the pending command completes
		set_config('1, '1, 16'd1);
		tick();
		send_frame(32'h0C5, NORMAL_BITS);
		send_frame(32'h10A, NORMAL_BITS);
		send_frame(32'h1FF, NORMAL_BITS);
		send_frame({8'd0, 6'd1, 6'd2, 6'd3, 6'd4}, ADVANCED_BITS);
		send_frame({26'd0, CODE_GO_ADVANCED}, NORMAL_BITS);
		send_frame(32'h005, NORMAL_BITS);
		send_frame({8'd0, 6'd1, 6'd2, 6'd3, 6'd4}, ADVANCED_BITS);
		send_frame(32'hFFFF_FFFF, 30);
		send_frame({8'd0, CODE_GO_NORMAL}, ADVANCED_BITS);

		// one instrument only: empty and partial advanced plays, zero timeout
		set_config('0, 64'h8000_0000_0000_0000, 16'd0);
		send_frame({26'd0, CODE_GO_ADVANCED}, NORMAL_BITS);
		send_frame({8'd0, 6'd0, 6'd1, 6'd2, 6'd3}, ADVANCED_BITS);
		send_frame({8'd0, 6'd63, 6'd5, 6'd6, 6'd63}, ADVANCED_BITS);
		send_frame({8'd0, CODE_GO_NORMAL}, ADVANCED_BITS);

		// not advanced-capable: the enter code is an ordinary melody
		set_config('1, '0, 16'd2);
		send_frame({23'd0, 3'b100, CODE_GO_ADVANCED}, NORMAL_BITS);
		send_frame({26'd0, CODE_SILENT}, NORMAL_BITS);

		// longest timeout: the command stays pending through a short silence
		set_config('1, '1, 16'hFFFF);
		tick_limit = 20;
		no_gaps = 1'b1;
		send_frame(32'h14F, NORMAL_BITS);
		no_gaps = 1'b0;

		// random register settings and command streams
		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			set_config(pick_map(), pick_map(), 16'($urandom_range(0, 6)));
			no_gaps = ($urandom_range(0, 3) == 0);
			repeat (8) random_transfer();
		end

		item.valid <= 1'b0;
		while (waiting != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		$display("sent %0d pin change and tick requests under %0d register settings",
			items_sent, phases + 1);
		$display("checked %0d replies: %0d stop, %0d play, %0d append",
			replies_checked, stops_seen, plays_seen, appends_seen);
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
